@@ design/eiku_pkg.sv @@
// Shared types for the eikonal upwind node update pipeline.
package eiku_pkg;

  // Per-stage control that travels beside the payload
  typedef struct packed {
    logic valid;     // stage holds a word
    logic bypass;    // node passes its present value through
    logic two_axis;  // quadratic candidate replaces the one-axis one
  } ctl_t;

endpackage

@@ design/eikonal_upwind_node_update_top.sv @@
// Eikonal upwind (Godunov) node update, 2D: deep pipeline top level.
//
// One grid node word enters per cycle while input ready is high and one result
// word leaves per cycle while output ready is high. The pipeline has seven front
// stages for axis pick and the wide products, a 2*VALUE_BITS-stage square root,
// two stages for the numerator, a 4*VALUE_BITS-stage divider and three back
// stages. The divider stage count sets the depth. A two-entry output buffer
// keeps input ready high while one result waits on the output; input ready
// falls only when both are full. The user must write inverse_speed through the
// cfg port only while no node is in flight; the block does not enforce it.
module eikonal_upwind_node_update_top #(
  parameter int VALUE_BITS    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // current_value, value_left, dist_left, value_right, dist_right,
  // value_down, dist_down, value_up, dist_up (lowest bits first)
  input  logic [((9*VALUE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // fixed_node
  input  logic                                   s_axis_tuser,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // new_value
  output logic [((VALUE_BITS+7)/8)*8-1:0]        m_axis_tdata,
  // was_updated
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic [VALUE_BITS-1:0]                  cfg_data_i,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o
);
  import eiku_pkg::*;

  localparam int V      = VALUE_BITS;
  localparam int F      = FRACTION_BITS;
  localparam int W      = 4 * V;
  localparam int OUT_W  = ((V + 7) / 8) * 8;
  localparam int IN_W   = ((9 * V + 7) / 8) * 8;
  localparam int SQ_SW  = 10 * V + 1;
  localparam int DV_SW  = 3 * V;
  localparam logic [V-1:0]   INF    = '1;
  localparam logic [2*V:0]   HALF_S = (2*V+1)'(1) << (F - 1);
  localparam logic [2*V:0]   INF_S  = (2*V+1)'(INF);
  localparam logic [W:0]     HALF_W = (W+1)'(1) << (F - 1);
  localparam logic [W:0]     INF_W  = (W+1)'(INF);

  // picks {value, spacing} of one axis from its two neighbors
  function automatic logic [2*V-1:0] pick_axis(input logic [V-1:0] vm, input logic [V-1:0] dm,
                                               input logic [V-1:0] vp, input logic [V-1:0] dp);
    logic [2*V-1:0] r;
    if (dm[V-1] && dp[V-1]) begin
      r = {INF, {V{1'b0}}};
    end else if (dm[V-1]) begin
      r = {vp, dp};
    end else if (dp[V-1]) begin
      r = {vm, dm};
    end else if (vm < vp) begin
      r = {vm, dm};
    end else begin
      r = {vp, dp};
    end
    return r;
  endfunction

  logic en;
  logic skid_v_q;
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  // inverse speed register
  logic [V-1:0] inv_speed_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_speed_q <= V'(1) << F;
    end else if (cfg_valid_i) begin
      inv_speed_q <= cfg_data_i;
    end
  end

  // front valid chain, stages 0 to 6
  logic [6:0] pre_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q <= '0;
    end else if (en) begin
      pre_v_q <= {pre_v_q[5:0], s_axis_tvalid};
    end
  end

  // stage 0: input register
  logic [IN_W-1:0] in_q;
  logic            fix_q;

  // stage 1: axis pick and sort
  logic [2*V-1:0] px, py;
  logic [V-1:0]   ax, hx, ay, hy;
  logic           byp_c;
  logic [V-1:0]   cur1_q, a0_1_q, h0_1_q, a1_1_q, h1_1_q;
  logic           byp1_q;

  assign px = pick_axis(in_q[2*V-1:V], in_q[3*V-1:2*V], in_q[4*V-1:3*V], in_q[5*V-1:4*V]);
  assign py = pick_axis(in_q[6*V-1:5*V], in_q[7*V-1:6*V], in_q[8*V-1:7*V], in_q[9*V-1:8*V]);
  assign ax = px[2*V-1:V];
  assign hx = px[V-1:0];
  assign ay = py[2*V-1:V];
  assign hy = py[V-1:0];
  assign byp_c = fix_q || (inv_speed_q == INF) || ((ax == INF) && (ay == INF));

  // stage 2: narrow products
  logic [2*V-1:0] h0f2_q, h0sq2_q, h1sq2_q, ff2_q, dd2_q, hh2_q;
  logic [V-1:0]   d_c, d2_q, a0_2_q, a1_2_q, cur2_q;
  logic           byp2_q;
  assign d_c = a1_1_q - a0_1_q;

  // stage 3: one-axis candidate and square sum
  logic [2*V:0]   one_c, s_c;
  logic           need_c;
  logic [V-1:0]   cand1_c;
  logic           need3_q, byp3_q;
  logic [V-1:0]   cand1_3_q, d3_q, a0_3_q, cur3_q;
  logic [2*V:0]   s3_q;
  logic [2*V-1:0] ff3_q, hh3_q, h0sq3_q;
  logic [W-1:0]   d2sh3_q;

  assign one_c   = (2*V+1)'(a0_2_q) + (({1'b0, h0f2_q} + HALF_S) >> F);
  assign s_c     = {1'b0, h0sq2_q} + {1'b0, h1sq2_q};
  assign need_c  = (a1_2_q != INF) && (one_c > (2*V+1)'(a1_2_q)) && (s_c != '0);
  assign cand1_c = (one_c >= INF_S) ? INF : one_c[V-1:0];

  // stage 4: partial products of f^2*S and d*h0^2
  logic [2*V-1:0] pfs_ll4_q, pfs_hl4_q, pdh_l4_q, pdh_h4_q;
  logic [2*V:0]   pfs_lh4_q, pfs_hh4_q;
  logic           need4_q, byp4_q;
  logic [V-1:0]   cand1_4_q, a0_4_q, cur4_q;
  logic [2*V:0]   s4_q;
  logic [2*V-1:0] hh4_q;
  logic [W-1:0]   d2sh4_q;

  // stage 5: partial sums
  logic [W-1:0]   fs5_q, d2sh5_q;
  logic [3*V-1:0] dh5_q;
  logic           need5_q, byp5_q;
  logic [V-1:0]   cand1_5_q, a0_5_q, cur5_q;
  logic [2*V:0]   s5_q;
  logic [2*V-1:0] hh5_q;

  // stage 6: radicand clamped at zero
  logic [W-1:0]   rad6_q;
  logic [3*V-1:0] dh6_q;
  logic           need6_q, byp6_q;
  logic [V-1:0]   cand1_6_q, a0_6_q, cur6_q;
  logic [2*V:0]   s6_q;
  logic [2*V-1:0] hh6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q  <= s_axis_tdata;
      fix_q <= s_axis_tuser;

      cur1_q <= in_q[V-1:0];
      byp1_q <= byp_c;
      if (ax > ay) begin
        a0_1_q <= ay;
        h0_1_q <= hy;
        a1_1_q <= ax;
        h1_1_q <= hx;
      end else begin
        a0_1_q <= ax;
        h0_1_q <= hx;
        a1_1_q <= ay;
        h1_1_q <= hy;
      end

      h0f2_q  <= h0_1_q * inv_speed_q;
      h0sq2_q <= h0_1_q * h0_1_q;
      h1sq2_q <= h1_1_q * h1_1_q;
      ff2_q   <= inv_speed_q * inv_speed_q;
      dd2_q   <= d_c * d_c;
      hh2_q   <= h0_1_q * h1_1_q;
      d2_q    <= d_c;
      a0_2_q  <= a0_1_q;
      a1_2_q  <= a1_1_q;
      cur2_q  <= cur1_q;
      byp2_q  <= byp1_q;

      need3_q   <= need_c;
      cand1_3_q <= cand1_c;
      s3_q      <= s_c;
      ff3_q     <= ff2_q;
      hh3_q     <= hh2_q;
      h0sq3_q   <= h0sq2_q;
      d3_q      <= d2_q;
      d2sh3_q   <= W'(dd2_q) << (2 * F);
      a0_3_q    <= a0_2_q;
      cur3_q    <= cur2_q;
      byp3_q    <= byp2_q;

      pfs_ll4_q <= ff3_q[V-1:0] * s3_q[V-1:0];
      pfs_lh4_q <= ff3_q[V-1:0] * s3_q[2*V:V];
      pfs_hl4_q <= ff3_q[2*V-1:V] * s3_q[V-1:0];
      pfs_hh4_q <= ff3_q[2*V-1:V] * s3_q[2*V:V];
      pdh_l4_q  <= d3_q * h0sq3_q[V-1:0];
      pdh_h4_q  <= d3_q * h0sq3_q[2*V-1:V];
      need4_q   <= need3_q;
      cand1_4_q <= cand1_3_q;
      s4_q      <= s3_q;
      hh4_q     <= hh3_q;
      d2sh4_q   <= d2sh3_q;
      a0_4_q    <= a0_3_q;
      cur4_q    <= cur3_q;
      byp4_q    <= byp3_q;

      fs5_q     <= W'(pfs_ll4_q) + (W'(pfs_lh4_q) << V) + (W'(pfs_hl4_q) << V)
                   + (W'(pfs_hh4_q) << (2 * V));
      dh5_q     <= (3*V)'(pdh_l4_q) + ((3*V)'(pdh_h4_q) << V);
      d2sh5_q   <= d2sh4_q;
      need5_q   <= need4_q;
      cand1_5_q <= cand1_4_q;
      s5_q      <= s4_q;
      hh5_q     <= hh4_q;
      a0_5_q    <= a0_4_q;
      cur5_q    <= cur4_q;
      byp5_q    <= byp4_q;

      rad6_q    <= (fs5_q > d2sh5_q) ? (fs5_q - d2sh5_q) : '0;
      dh6_q     <= dh5_q;
      need6_q   <= need5_q;
      cand1_6_q <= cand1_5_q;
      s6_q      <= s5_q;
      hh6_q     <= hh5_q;
      a0_6_q    <= a0_5_q;
      cur6_q    <= cur5_q;
      byp6_q    <= byp5_q;
    end
  end

  // square root of the radicand
  ctl_t             sq_ctl_in, sq_ctl;
  logic [2*V-1:0]   sq_root;
  logic [SQ_SW-1:0] sq_side;
  logic [2*V-1:0]   sq_hh;
  logic [3*V-1:0]   sq_dh;
  logic [2*V:0]     sq_s;
  logic [V-1:0]     sq_a0, sq_cur, sq_cand1;

  assign sq_ctl_in = '{valid: pre_v_q[6], bypass: byp6_q, two_axis: need6_q};

  eiku_sqrt #(
    .VALUE_BITS (V),
    .SIDE_W     (SQ_SW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (sq_ctl_in),
    .rad_i  (rad6_q),
    .side_i ({hh6_q, dh6_q, s6_q, a0_6_q, cur6_q, cand1_6_q}),
    .ctl_o  (sq_ctl),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  assign {sq_hh, sq_dh, sq_s, sq_a0, sq_cur, sq_cand1} = sq_side;

  // stages 7 and 8: numerator d*h0^2*2^F + h0*h1*r
  ctl_t           ctl7_q, ctl8_q;
  logic [2*V-1:0] phr_ll7_q, phr_lh7_q, phr_hl7_q, phr_hh7_q;
  logic [W-1:0]   npre7_q, num8_q;
  logic [2*V:0]   s7_q, s8_q;
  logic [V-1:0]   a0_7_q, cur7_q, cand1_7_q, a0_8_q, cur8_q, cand1_8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl7_q <= '0;
      ctl8_q <= '0;
    end else if (en) begin
      ctl7_q <= sq_ctl;
      ctl8_q <= ctl7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      phr_ll7_q <= sq_hh[V-1:0] * sq_root[V-1:0];
      phr_lh7_q <= sq_hh[V-1:0] * sq_root[2*V-1:V];
      phr_hl7_q <= sq_hh[2*V-1:V] * sq_root[V-1:0];
      phr_hh7_q <= sq_hh[2*V-1:V] * sq_root[2*V-1:V];
      npre7_q   <= W'(sq_dh) << F;
      s7_q      <= sq_s;
      a0_7_q    <= sq_a0;
      cur7_q    <= sq_cur;
      cand1_7_q <= sq_cand1;

      num8_q    <= npre7_q + W'(phr_ll7_q) + (W'(phr_lh7_q) << V) + (W'(phr_hl7_q) << V)
                   + (W'(phr_hh7_q) << (2 * V));
      s8_q      <= s7_q;
      a0_8_q    <= a0_7_q;
      cur8_q    <= cur7_q;
      cand1_8_q <= cand1_7_q;
    end
  end

  // divide by the square sum
  ctl_t             dv_ctl;
  logic [W-1:0]     dv_quo;
  logic [DV_SW-1:0] dv_side;
  logic [V-1:0]     dv_a0, dv_cur, dv_cand1;

  eiku_div #(
    .VALUE_BITS (V),
    .SIDE_W     (DV_SW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (ctl8_q),
    .num_i  (num8_q),
    .den_i  (s8_q),
    .side_i ({a0_8_q, cur8_q, cand1_8_q}),
    .ctl_o  (dv_ctl),
    .quo_o  (dv_quo),
    .side_o (dv_side)
  );

  assign {dv_a0, dv_cur, dv_cand1} = dv_side;

  // stage 9: candidate select, stage 10: minimum with present value
  logic [W:0]   sum2_c;
  logic [V-1:0] cand2_c;
  ctl_t         ctl9_q, ctl10_q;
  logic [V-1:0] cand9_q, cur9_q, val10_q;
  logic         upd10_q, lt_c;

  assign sum2_c  = (W+1)'(dv_a0) + (({1'b0, dv_quo} + HALF_W) >> F);
  assign cand2_c = (sum2_c >= INF_W) ? INF : sum2_c[V-1:0];
  assign lt_c    = (cand9_q < cur9_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl9_q  <= '0;
      ctl10_q <= '0;
    end else if (en) begin
      ctl9_q  <= dv_ctl;
      ctl10_q <= ctl9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cand9_q <= dv_ctl.two_axis ? cand2_c : dv_cand1;
      cur9_q  <= dv_cur;
      val10_q <= (!ctl9_q.bypass && lt_c) ? cand9_q : cur9_q;
      upd10_q <= !ctl9_q.bypass && lt_c;
    end
  end

  // output register plus skid entry
  logic         out_v_q, out_free;
  logic [V-1:0] out_val_q, skid_val_q;
  logic         out_upd_q, skid_upd_q;

  assign out_free = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_free) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (ctl10_q.valid) begin
      if (out_free) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (out_free) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_free) begin
        out_val_q <= skid_val_q;
        out_upd_q <= skid_upd_q;
      end
    end else if (ctl10_q.valid) begin
      if (out_free) begin
        out_val_q <= val10_q;
        out_upd_q <= upd10_q;
      end else begin
        skid_val_q <= val10_q;
        skid_upd_q <= upd10_q;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_W'(out_val_q);
  assign m_axis_tuser  = out_upd_q;

endmodule

@@ design/eiku_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module eiku_sqrt #(
  parameter int VALUE_BITS = 32,
  parameter int SIDE_W     = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  eiku_pkg::ctl_t            ctl_i,
  input  logic [4*VALUE_BITS-1:0]   rad_i,
  input  logic [SIDE_W-1:0]         side_i,
  output eiku_pkg::ctl_t            ctl_o,
  output logic [2*VALUE_BITS-1:0]   root_o,
  output logic [SIDE_W-1:0]         side_o
);
  import eiku_pkg::*;

  localparam int V  = VALUE_BITS;
  localparam int W  = 4 * V;
  localparam int N  = 2 * V;
  localparam int RW = 2 * V + 2;

  ctl_t              ctl_q  [N];
  logic [RW-1:0]     rem_q  [N];
  logic [N-1:0]      root_q [N];
  logic [W-1:0]      rad_q  [N];
  logic [SIDE_W-1:0] side_q [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    ctl_t              c_in;
    logic [RW-1:0]     r_in;
    logic [N-1:0]      rt_in;
    logic [W-1:0]      a_in;
    logic [SIDE_W-1:0] s_in;
    logic [RW+1:0]     t;
    logic [RW+1:0]     trial;
    logic              take;

    if (i == 0) begin : g_first
      assign c_in  = ctl_i;
      assign r_in  = '0;
      assign rt_in = '0;
      assign a_in  = rad_i;
      assign s_in  = side_i;
    end else begin : g_next
      assign c_in  = ctl_q[i-1];
      assign r_in  = rem_q[i-1];
      assign rt_in = root_q[i-1];
      assign a_in  = rad_q[i-1];
      assign s_in  = side_q[i-1];
    end

    // bring down two radicand bits, try 4*root+1
    assign t     = {r_in, a_in[W-1:W-2]};
    assign trial = (RW+2)'({rt_in, 2'b01});
    assign take  = (t >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[i] <= '0;
      end else if (en_i) begin
        ctl_q[i] <= c_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= take ? RW'(t - trial) : RW'(t);
        root_q[i] <= {rt_in[N-2:0], take};
        rad_q[i]  <= a_in << 2;
        side_q[i] <= s_in;
      end
    end
  end

  assign ctl_o  = ctl_q[N-1];
  assign root_o = root_q[N-1];
  assign side_o = side_q[N-1];

endmodule

@@ design/eiku_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module eiku_div #(
  parameter int VALUE_BITS = 32,
  parameter int SIDE_W     = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  eiku_pkg::ctl_t            ctl_i,
  input  logic [4*VALUE_BITS-1:0]   num_i,
  input  logic [2*VALUE_BITS:0]     den_i,
  input  logic [SIDE_W-1:0]         side_i,
  output eiku_pkg::ctl_t            ctl_o,
  output logic [4*VALUE_BITS-1:0]   quo_o,
  output logic [SIDE_W-1:0]         side_o
);
  import eiku_pkg::*;

  localparam int V  = VALUE_BITS;
  localparam int W  = 4 * V;
  localparam int RW = 2 * V + 1;

  ctl_t              ctl_q  [W];
  logic [RW-1:0]     rem_q  [W];
  logic [W-1:0]      nq_q   [W];
  logic [RW-1:0]     den_q  [W];
  logic [SIDE_W-1:0] side_q [W];

  for (genvar i = 0; i < W; i++) begin : g_step
    ctl_t              c_in;
    logic [RW-1:0]     r_in;
    logic [W-1:0]      n_in;
    logic [RW-1:0]     d_in;
    logic [SIDE_W-1:0] s_in;
    logic [RW:0]       t;
    logic              take;

    if (i == 0) begin : g_first
      assign c_in = ctl_i;
      assign r_in = '0;
      assign n_in = num_i;
      assign d_in = den_i;
      assign s_in = side_i;
    end else begin : g_next
      assign c_in = ctl_q[i-1];
      assign r_in = rem_q[i-1];
      assign n_in = nq_q[i-1];
      assign d_in = den_q[i-1];
      assign s_in = side_q[i-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign t    = {r_in, n_in[W-1]};
    assign take = (t >= {1'b0, d_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[i] <= '0;
      end else if (en_i) begin
        ctl_q[i] <= c_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= take ? RW'(t - {1'b0, d_in}) : RW'(t);
        nq_q[i]   <= {n_in[W-2:0], take};
        den_q[i]  <= d_in;
        side_q[i] <= s_in;
      end
    end
  end

  assign ctl_o  = ctl_q[W-1];
  assign quo_o  = nq_q[W-1];
  assign side_o = side_q[W-1];

endmodule

@@ design/eiku_checker.sv @@
// Port-level checks for the eikonal node update top level, with its bind.
module eiku_port_checker #(
  parameter int VALUE_BITS = 32
) (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   s_axis_tready,
  input logic [((VALUE_BITS+7)/8)*8-1:0]        m_axis_tdata,
  input logic                                   m_axis_tuser,
  input logic                                   m_axis_tvalid,
  input logic                                   m_axis_tready
);

  // no output word during reset
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output word valid during reset");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled output word changed");

  // input back-pressure only while a result is waiting
  a_bp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no output word pending");

  // an updated node can never read as infinity
  a_upd_finite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[VALUE_BITS-1:0] != '1)
    else $error("updated node reports infinity");

endmodule

bind eikonal_upwind_node_update_top eiku_port_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_eiku_checker (.*);

@@ tb/sv/eiku_checker.sv @@
// Checker for the eikonal node update: watches both streams, predicts and compares.
module eiku_checker #(
  parameter int VALUE_BITS    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [287:0]                s_axis_tdata,
  input  logic                        s_axis_tuser,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [31:0]                 m_axis_tdata,
  input  logic                        m_axis_tuser,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [VALUE_BITS-1:0]       cfg_data_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_o,
  output int                          fail_count_o,
  output int                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] INF = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] new_value;
    logic        was_updated;
  } node_result_t;

  node_result_t  node_results_q[$];
  logic [31:0]   speed_inv;

  // Axis pick: smaller non-wall neighbor, plus side wins ties
  function automatic void pick_axis(input logic [31:0] vm, input logic [31:0] dm,
                                    input logic [31:0] vp, input logic [31:0] dp,
                                    output logic [31:0] a, output logic [31:0] h);
    if (dm[31] && dp[31]) begin
      a = INF; h = 0;
    end else if (dm[31]) begin
      a = vp; h = dp;
    end else if (dp[31]) begin
      a = vm; h = dm;
    end else if (vm < vp) begin
      a = vm; h = dm;
    end else begin
      a = vp; h = dp;
    end
  endfunction

  function automatic logic [63:0] isqrt128(input logic [127:0] n);
    logic [63:0]  res;
    logic [63:0]  c;
    res = 0;
    for (int b = 63; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if (128'(c) * 128'(c) <= n) res = c;
    end
    return res;
  endfunction

  function automatic logic [31:0] sat128(input logic [127:0] w);
    return (w >= 128'(INF)) ? INF : w[31:0];
  endfunction

  // Godunov update of one node
  function automatic node_result_t update_node(input logic [287:0] d, input logic fixd);
    logic [31:0]  cur, a0, h0, a1, h1, t, cand, dd;
    logic [127:0] one, h0sq, s, fs, d2, rad, num, q;
    logic [63:0]  r;
    node_result_t res;
    cur = d[31:0];
    pick_axis(d[63:32], d[95:64], d[127:96], d[159:128], a0, h0);
    pick_axis(d[191:160], d[223:192], d[255:224], d[287:256], a1, h1);
    if (fixd || speed_inv == INF || (a0 == INF && a1 == INF)) begin
      res.new_value = cur; res.was_updated = 0;
      return res;
    end
    if (a0 > a1) begin
      t = a0; a0 = a1; a1 = t;
      t = h0; h0 = h1; h1 = t;
    end
    one = 128'(a0) + ((128'(h0) * 128'(speed_inv) + (128'd1 << (FRACTION_BITS-1)))
          >> FRACTION_BITS);
    cand = sat128(one);
    if (a1 != INF && one > 128'(a1)) begin
      h0sq = 128'(h0) * 128'(h0);
      s = h0sq + 128'(h1) * 128'(h1);
      if (s != 0) begin
        dd = a1 - a0;
        fs = 128'(speed_inv) * 128'(speed_inv) * s;
        d2 = (128'(dd) * 128'(dd)) << (2*FRACTION_BITS);
        rad = (fs > d2) ? fs - d2 : 0;
        r = isqrt128(rad);
        num = ((128'(dd) * h0sq) << FRACTION_BITS) + 128'(h0) * 128'(h1) * 128'(r);
        q = num / s;
        cand = sat128(128'(a0) + ((q + (128'd1 << (FRACTION_BITS-1))) >> FRACTION_BITS));
      end
    end
    res.new_value = (cand < cur) ? cand : cur;
    res.was_updated = cand < cur;
    return res;
  endfunction

  assign pending_o = node_results_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    node_result_t e;
    int errs;
    if (!rst_ni) begin
      speed_inv    <= 32'h0001_0000;
      fail_count_o <= 0;
      node_results_q.delete();
    end else begin
      errs = 0;
      if (cfg_valid_i && cfg_ready_o) speed_inv <= cfg_data_i;
      if (s_axis_tvalid && s_axis_tready)
        node_results_q.push_back(update_node(s_axis_tdata, s_axis_tuser));
      if (m_axis_tvalid && m_axis_tready) begin
        if (node_results_q.size() == 0) begin
          $error("result word with none expected: new_value %h", m_axis_tdata);
          errs++;
        end else begin
          e = node_results_q.pop_front();
          if (m_axis_tdata !== e.new_value) begin
            $error("new_value exp %h got %h", e.new_value, m_axis_tdata);
            errs++;
          end
          if (m_axis_tuser !== e.was_updated) begin
            $error("was_updated exp %b got %b", e.was_updated, m_axis_tuser);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
  end
endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the eikonal node update: stimulus, config phases and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 6*32 + 12;
  localparam int CYCLE_LIMIT = 400000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic [287:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [31:0]  cfg_data_i = '0;
  logic         cfg_valid_i = 0;
  logic         cfg_ready_o;
  int           fail_count, pending;
  int           cycles = 0;
  int           out_gap = 0;
  logic         out_stall_en = 1;

  always #5 clk_i = ~clk_i;

  eikonal_upwind_node_update_top dut (.*);

  eiku_checker chk (.*, .fail_count_o(fail_count), .pending_o(pending));

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output side back-pressure: random stall runs, mostly short
  always @(posedge clk_i) begin
    if (!out_stall_en) begin
      m_axis_tready <= 1;
    end else if (out_gap > 0) begin
      m_axis_tready <= 0;
      out_gap       <= out_gap - 1;
    end else begin
      m_axis_tready <= 1;
      out_gap       <= gap_len();
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return $urandom_range(0, 3);
      2: return $urandom_range(0, 32'h0010_0000);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_spacing();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000 | $urandom;
      1: return 0;
      2: return 32'h7FFF_FFFF;
      3: return $urandom;
      default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
    endcase
  endfunction

  // Valid stays high into the next word when there is no gap
  task automatic send_node(input logic [287:0] d, input logic fixd);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tdata  <= d;
    s_axis_tuser  <= fixd;
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Node with neighbor values near each other so the quadratic path is hit
  task automatic send_random_node();
    logic [287:0] d;
    logic [31:0]  base;
    base = $urandom_range(0, 32'h0100_0000);
    for (int i = 0; i < 9; i++) d[i*32 +: 32] = (i % 2) ? rand_value() : rand_spacing();
    d[31:0] = rand_value();
    if ($urandom_range(0, 3) != 0) begin
      for (int i = 1; i < 9; i += 2)
        d[i*32 +: 32] = base + $urandom_range(0, 32'h0002_0000);
      for (int i = 2; i < 9; i += 2)
        if ($urandom_range(0, 5) != 0) d[i*32 +: 32] = $urandom_range(0, 32'h0002_0000);
      if ($urandom_range(0, 1)) d[31:0] = 32'hFFFF_FFFF;
    end else begin
      for (int i = 1; i < 9; i++) d[i*32 +: 32] = (i % 2) ? rand_value() : rand_spacing();
    end
    send_node(d, $urandom_range(0, 9) == 0);
  endtask

  // Stop input, wait for drain, then a register write
  task automatic write_speed(input logic [31:0] v);
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_data_i  <= v;
    cfg_valid_i <= 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
  endtask

  function automatic logic [287:0] pack_node(input logic [31:0] cur,
      input logic [31:0] vl, input logic [31:0] dl, input logic [31:0] vr,
      input logic [31:0] dr, input logic [31:0] vd, input logic [31:0] dd,
      input logic [31:0] vu, input logic [31:0] du);
    return {du, vu, dd, vd, dr, vr, dl, vl, cur};
  endfunction

  initial begin
    logic [31:0] one;
    logic [31:0] speeds[5];
    one = 32'h0001_0000;
    speeds = '{32'h0000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0002_8000, 32'h0001_0000};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: fixed node, walls, ties, infinities, zero spacing, extremes
    send_node(pack_node(32'hFFFF_FFFF, 0, one, 0, one, 0, one, 0, one), 1);
    send_node(pack_node(32'hFFFF_FFFF, 32'hFFFF_FFFF, one, 32'hFFFF_FFFF, one,
                        32'hFFFF_FFFF, one, 32'hFFFF_FFFF, one), 0);
    send_node(pack_node(32'hFFFF_FFFF, 0, 32'h8000_0000, 5, 32'hFFFF_FFFF,
                        0, one, 0, one), 0);
    send_node(pack_node(32'hFFFF_FFFF, 7, one, 7, 2*one, 7, one, 7, 3*one), 0);
    send_node(pack_node(32'hFFFF_FFFF, one, one, 2*one, one, one, one, 2*one, one), 0);
    send_node(pack_node(32'hFFFF_FFFF, one, one, one, one, 32'hFFFF_FFFF, one,
                        32'hFFFF_FFFF, one), 0);
    send_node(pack_node(32'hFFFF_FFFF, one, 0, one, 0, one, 0, one, 0), 0);
    send_node(pack_node(32'hFFFF_FFFF, one, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h7FFF_FFFF,
                        one, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h7FFF_FFFF), 0);
    send_node(pack_node(0, one, one, one, one, one, one, one, one), 0);
    send_node(pack_node(32'hFFFF_FFFE, 32'hFFFF_FFFE, one, 32'hFFFF_FFFE, one,
                        32'hFFFF_FFFE, one, 32'hFFFF_FFFE, one), 0);
    send_node(pack_node(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555,
                        32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555,
                        32'hAAAA_AAAA), 0);
    send_node(pack_node(32'hFFFF_FFFF, 3*one, one, 32'hFFFF_FFFF, 32'h8000_0000,
                        0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF), 0);
    for (int i = 0; i < 8; i++) send_random_node();

    // Random phases over several inverse speed settings
    foreach (speeds[k]) begin
      write_speed(speeds[k]);
      for (int i = 0; i < 260; i++) begin
        if (i == 130) out_stall_en <= 0;
        if (i == 180) out_stall_en <= 1;
        send_random_node();
      end
    end

    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (fail_count == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
